// ===== rtl/cmfs_pkg.sv =====
`timescale 1ns / 1ps

package cmfs_pkg;

	localparam int CMFS_COMPONENT_WIDTH = 16;
	localparam int CMFS_UV_FRACTION_BITS = 16;

	localparam int FACE_W = 3;

	typedef logic [FACE_W-1:0] face_t;

	localparam face_t FACE_POS_X = 3'd0;
	localparam face_t FACE_NEG_X = 3'd1;
	localparam face_t FACE_NEG_Y = 3'd2;
	localparam face_t FACE_POS_Y = 3'd3;
	localparam face_t FACE_POS_Z = 3'd4;
	localparam face_t FACE_NEG_Z = 3'd5;

	// sideband that rides along with each beat through the divider
	typedef struct packed {
		face_t face;
		logic  degenerate;
	} side_t;

endpackage

// ===== rtl/cmfs_select.sv =====
`timescale 1ns / 1ps

module cmfs_select #(
	parameter int W = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [W-1:0]   dir_x,
	input  logic signed [W-1:0]   dir_y,
	input  logic signed [W-1:0]   dir_z,
	output logic                  out_valid,
	input  logic                  out_ready,
	output cmfs_pkg::side_t       side,
	output logic [W-1:0]          mag,
	output logic signed [W:0]     num_u,
	output logic signed [W:0]     num_v
);
	import cmfs_pkg::*;

	logic                vld_s1;
	logic                rdy_s1;
	logic signed [W-1:0] x_s1, y_s1, z_s1;
	logic [W-1:0]        ax_s1, ay_s1, az_s1;

	logic                vld_s2;
	logic                rdy_s2;
	side_t               side_s2;
	logic [W-1:0]        mag_s2;
	logic signed [W:0]   nu_s2, nv_s2;

	logic [W-1:0]        ax_c, ay_c, az_c;
	logic signed [W:0]   xe, ye, ze;
	side_t               side_c;
	logic [W-1:0]        mag_c;
	logic signed [W:0]   nu_c, nv_c;
	logic                x_major, y_major;

	// magnitude of the most negative value comes out exact as unsigned
	assign ax_c = dir_x[W-1] ? (~dir_x + 1'b1) : dir_x;
	assign ay_c = dir_y[W-1] ? (~dir_y + 1'b1) : dir_y;
	assign az_c = dir_z[W-1] ? (~dir_z + 1'b1) : dir_z;

	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign rdy_s2 = !vld_s2 || out_ready;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			x_s1  <= dir_x;
			y_s1  <= dir_y;
			z_s1  <= dir_z;
			ax_s1 <= ax_c;
			ay_s1 <= ay_c;
			az_s1 <= az_c;
		end
	end

	assign xe = {x_s1[W-1], x_s1};
	assign ye = {y_s1[W-1], y_s1};
	assign ze = {z_s1[W-1], z_s1};

	// ties fall to y over x, then to z
	assign x_major = (ax_s1 > ay_s1) && (ax_s1 > az_s1);
	assign y_major = ay_s1 > az_s1;

	always_comb begin
		side_c.degenerate = !((|ax_s1) || (|ay_s1) || (|az_s1));
		priority if (x_major) begin
			mag_c = ax_s1;
			nv_c  = -ye;
			if (!x_s1[W-1]) begin
				side_c.face = FACE_POS_X;
				nu_c        = -ze;
			end else begin
				side_c.face = FACE_NEG_X;
				nu_c        = ze;
			end
		end else if (y_major) begin
			mag_c = ay_s1;
			nu_c  = xe;
			if (!y_s1[W-1]) begin
				side_c.face = FACE_POS_Y;
				nv_c        = ze;
			end else begin
				side_c.face = FACE_NEG_Y;
				nv_c        = -ze;
			end
		end else begin
			mag_c = az_s1;
			nv_c  = -ye;
			if (!z_s1[W-1] && (|z_s1)) begin
				side_c.face = FACE_POS_Z;
				nu_c        = xe;
			end else begin
				side_c.face = FACE_NEG_Z;
				nu_c        = -xe;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			side_s2 <= side_c;
			mag_s2  <= mag_c;
			nu_s2   <= nu_c;
			nv_s2   <= nv_c;
		end
	end

	assign out_valid = vld_s2;
	assign side      = side_s2;
	assign mag       = mag_s2;
	assign num_u     = nu_s2;
	assign num_v     = nv_s2;

endmodule

// ===== rtl/cmfs_div_step.sv =====
`timescale 1ns / 1ps

module cmfs_div_step #(
	parameter int W   = 16,
	parameter int F   = 16,
	parameter int BIT = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cmfs_pkg::side_t side_in,
	input  logic [W:0]      div_in,
	input  logic [F:0]      nlo_u_in,
	input  logic [W-1:0]    rem_u_in,
	input  logic [F:0]      quo_u_in,
	input  logic [F:0]      nlo_v_in,
	input  logic [W-1:0]    rem_v_in,
	input  logic [F:0]      quo_v_in,
	output logic            out_valid,
	input  logic            out_ready,
	output cmfs_pkg::side_t side_out,
	output logic [W:0]      div_out,
	output logic [F:0]      nlo_u_out,
	output logic [W-1:0]    rem_u_out,
	output logic [F:0]      quo_u_out,
	output logic [F:0]      nlo_v_out,
	output logic [W-1:0]    rem_v_out,
	output logic [F:0]      quo_v_out
);
	import cmfs_pkg::*;

	logic         vld_s1;
	side_t        side_s1;
	logic [W:0]   div_s1;
	logic [F:0]   nlo_u_s1, quo_u_s1, nlo_v_s1, quo_v_s1;
	logic [W-1:0] rem_u_s1, rem_v_s1;

	logic [W:0]   trial_u, trial_v, diff_u, diff_v;
	logic         ge_u, ge_v;
	logic [W-1:0] rem_u_c, rem_v_c;
	logic [F:0]   quo_u_c, quo_v_c;

	// one restoring step per lane: remainder stays below the divisor
	assign trial_u = {rem_u_in, nlo_u_in[BIT]};
	assign trial_v = {rem_v_in, nlo_v_in[BIT]};
	assign ge_u    = trial_u >= div_in;
	assign ge_v    = trial_v >= div_in;
	assign diff_u  = trial_u - div_in;
	assign diff_v  = trial_v - div_in;
	assign rem_u_c = ge_u ? diff_u[W-1:0] : trial_u[W-1:0];
	assign rem_v_c = ge_v ? diff_v[W-1:0] : trial_v[W-1:0];

	always_comb begin
		quo_u_c      = quo_u_in;
		quo_v_c      = quo_v_in;
		quo_u_c[BIT] = ge_u;
		quo_v_c[BIT] = ge_v;
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			side_s1  <= side_in;
			div_s1   <= div_in;
			nlo_u_s1 <= nlo_u_in;
			rem_u_s1 <= rem_u_c;
			quo_u_s1 <= quo_u_c;
			nlo_v_s1 <= nlo_v_in;
			rem_v_s1 <= rem_v_c;
			quo_v_s1 <= quo_v_c;
		end
	end

	assign out_valid = vld_s1;
	assign side_out  = side_s1;
	assign div_out   = div_s1;
	assign nlo_u_out = nlo_u_s1;
	assign rem_u_out = rem_u_s1;
	assign quo_u_out = quo_u_s1;
	assign nlo_v_out = nlo_v_s1;
	assign rem_v_out = rem_v_s1;
	assign quo_v_out = quo_v_s1;

endmodule

// ===== rtl/cmfs_div.sv =====
`timescale 1ns / 1ps

module cmfs_div #(
	parameter int W = 16,
	parameter int F = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cmfs_pkg::side_t   side_in,
	input  logic [W-1:0]      mag,
	input  logic signed [W:0] num_u,
	input  logic signed [W:0] num_v,
	output logic              out_valid,
	input  logic              out_ready,
	output cmfs_pkg::side_t   side_out,
	output logic [F-1:0]      tex_u,
	output logic [F-1:0]      tex_v
);
	import cmfs_pkg::*;

	localparam int NW = W + F + 1;

	// offset stage: a = n + m lies in [0, 2m]
	logic         vld_s1, rdy_s1;
	side_t        side_s1;
	logic [W-1:0] mag_s1;
	logic [W:0]   a_u_s1, a_v_s1;

	// numerator stage: N = a * 2^F + m, divisor D = 2m
	logic          vld_s2, rdy_s2;
	side_t         side_s2;
	logic [W:0]    div_s2;
	logic [NW-1:0] n_u_s2, n_v_s2;

	logic          vld_c [F+2];
	logic          rdy_c [F+2];
	side_t         side_c [F+2];
	logic [W:0]    div_c [F+2];
	logic [F:0]    nlo_u_c [F+2];
	logic [W-1:0]  rem_u_c [F+2];
	logic [F:0]    quo_u_c [F+2];
	logic [F:0]    nlo_v_c [F+2];
	logic [W-1:0]  rem_v_c [F+2];
	logic [F:0]    quo_v_c [F+2];

	logic          vld_sn, rdy_sn;
	side_t         side_sn;
	logic [F-1:0]  tex_u_sn, tex_v_sn;
	logic [F-1:0]  tex_u_c, tex_v_c;

	localparam logic [F-1:0] UV_MID = {1'b1, {(F-1){1'b0}}};

	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign rdy_s2   = !vld_s2 || rdy_c[0];
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			side_s1 <= side_in;
			mag_s1  <= mag;
			// true sum is non-negative, so the wrapped bits read as unsigned
			a_u_s1  <= (W+1)'(num_u) + {1'b0, mag};
			a_v_s1  <= (W+1)'(num_v) + {1'b0, mag};
		end
		if (rdy_s2 && vld_s1) begin
			side_s2 <= side_s1;
			div_s2  <= {mag_s1, 1'b0};
			n_u_s2  <= {a_u_s1, {F{1'b0}}} + NW'(mag_s1);
			n_v_s2  <= {a_v_s1, {F{1'b0}}} + NW'(mag_s1);
		end
	end

	// upper bits of N are already below D, so quotient has F+1 bits
	assign vld_c[0]   = vld_s2;
	assign side_c[0]  = side_s2;
	assign div_c[0]   = div_s2;
	assign nlo_u_c[0] = n_u_s2[F:0];
	assign rem_u_c[0] = n_u_s2[NW-1:F+1];
	assign quo_u_c[0] = '0;
	assign nlo_v_c[0] = n_v_s2[F:0];
	assign rem_v_c[0] = n_v_s2[NW-1:F+1];
	assign quo_v_c[0] = '0;

	for (genvar k = 0; k <= F; k++) begin : g_step
		cmfs_div_step #(
			.W   (W),
			.F   (F),
			.BIT (F - k)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld_c[k]),
			.in_ready  (rdy_c[k]),
			.side_in   (side_c[k]),
			.div_in    (div_c[k]),
			.nlo_u_in  (nlo_u_c[k]),
			.rem_u_in  (rem_u_c[k]),
			.quo_u_in  (quo_u_c[k]),
			.nlo_v_in  (nlo_v_c[k]),
			.rem_v_in  (rem_v_c[k]),
			.quo_v_in  (quo_v_c[k]),
			.out_valid (vld_c[k+1]),
			.out_ready (rdy_c[k+1]),
			.side_out  (side_c[k+1]),
			.div_out   (div_c[k+1]),
			.nlo_u_out (nlo_u_c[k+1]),
			.rem_u_out (rem_u_c[k+1]),
			.quo_u_out (quo_u_c[k+1]),
			.nlo_v_out (nlo_v_c[k+1]),
			.rem_v_out (rem_v_c[k+1]),
			.quo_v_out (quo_v_c[k+1])
		);
	end

	assign rdy_sn      = !vld_sn || out_ready;
	assign rdy_c[F+1]  = rdy_sn;

	// a coordinate of exactly one saturates; zero vector gets mid values
	always_comb begin
		if (side_c[F+1].degenerate) begin
			tex_u_c = UV_MID;
			tex_v_c = UV_MID;
		end else begin
			tex_u_c = quo_u_c[F+1][F] ? {F{1'b1}} : quo_u_c[F+1][F-1:0];
			tex_v_c = quo_v_c[F+1][F] ? {F{1'b1}} : quo_v_c[F+1][F-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else if (rdy_sn) begin
			vld_sn <= vld_c[F+1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_sn && vld_c[F+1]) begin
			side_sn  <= side_c[F+1];
			tex_u_sn <= tex_u_c;
			tex_v_sn <= tex_v_c;
		end
	end

	assign out_valid = vld_sn;
	assign side_out  = side_sn;
	assign tex_u     = tex_u_sn;
	assign tex_v     = tex_v_sn;

endmodule

// ===== rtl/cubemap_face_select_uv.sv =====
`timescale 1ns / 1ps

// Cube map face select: takes a signed direction (x, y, z), picks the face of
// the largest-magnitude axis (ties to y over x, then to z) and returns the face
// code with two unsigned Q0.F in-face coordinates. One beat in and one beat out
// per clock when both sides flow. In order, the pipeline registers magnitude and
// face selection, the offset and numerator build, one restoring divide step per
// quotient bit (F + 1 stages), and an output register with saturation. Every
// stage has its own valid and ready, so a stalled output only backs up as far as
// it must and bubbles are squeezed out. An all-zero direction returns face 5,
// mid coordinates and tuser set.
module cubemap_face_select_uv #(
	parameter int COMPONENT_WIDTH  = cmfs_pkg::CMFS_COMPONENT_WIDTH,
	parameter int UV_FRACTION_BITS = cmfs_pkg::CMFS_UV_FRACTION_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// dir_x, dir_y, dir_z, zero fill
	input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// face, tex_u, tex_v, zero fill
	output logic [((cmfs_pkg::FACE_W+2*UV_FRACTION_BITS+7)/8)*8-1:0] m_axis_tdata,
	// degenerate
	output logic m_axis_tuser
);
	import cmfs_pkg::*;

	localparam int W       = COMPONENT_WIDTH;
	localparam int F       = UV_FRACTION_BITS;
	localparam int OUT_W   = ((FACE_W + 2*F + 7) / 8) * 8;
	localparam int OUT_PAD = OUT_W - FACE_W - 2*F;
	localparam logic [F-1:0] UV_MID = {1'b1, {(F-1){1'b0}}};

	logic              sel_valid, sel_ready;
	side_t             sel_side;
	logic [W-1:0]      sel_mag;
	logic signed [W:0] sel_nu, sel_nv;

	side_t             res_side;
	logic [F-1:0]      res_u, res_v;

	cmfs_select #(
		.W (W)
	) u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.dir_x     (s_axis_tdata[W-1:0]),
		.dir_y     (s_axis_tdata[2*W-1:W]),
		.dir_z     (s_axis_tdata[3*W-1:2*W]),
		.out_valid (sel_valid),
		.out_ready (sel_ready),
		.side      (sel_side),
		.mag       (sel_mag),
		.num_u     (sel_nu),
		.num_v     (sel_nv)
	);

	cmfs_div #(
		.W (W),
		.F (F)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sel_valid),
		.in_ready  (sel_ready),
		.side_in   (sel_side),
		.mag       (sel_mag),
		.num_u     (sel_nu),
		.num_v     (sel_nv),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.side_out  (res_side),
		.tex_u     (res_u),
		.tex_v     (res_v)
	);

	assign m_axis_tdata = {{OUT_PAD{1'b0}}, res_v, res_u, res_side.face};
	assign m_axis_tuser = res_side.degenerate;

	a_face_range : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res_side.face <= FACE_NEG_Z))
		else $error("face code out of range");

	a_degenerate_shape : assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res_side.degenerate) |->
		(res_side.face == FACE_NEG_Z && res_u == UV_MID && res_v == UV_MID))
		else $error("zero vector beat not forced to face 5 and mid coordinates");

	a_empty_out_ready : assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output register is empty");

endmodule

// ===== dv/cubemap_face_select_uv_checker.sv =====
`timescale 1ns / 1ps

module cubemap_face_select_uv_checker #(
	parameter int CW    = cmfs_pkg::CMFS_COMPONENT_WIDTH,
	parameter int FB    = cmfs_pkg::CMFS_UV_FRACTION_BITS,
	parameter int IN_W  = ((3*CW+7)/8)*8,
	parameter int OUT_W = ((cmfs_pkg::FACE_W+2*FB+7)/8)*8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	// dir_x, dir_y, dir_z, zero fill
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             m_tvalid,
	input  logic             m_tready,
	// face, tex_u, tex_v, zero fill
	input  logic [OUT_W-1:0] m_tdata,
	// degenerate
	input  logic             m_tuser,
	output int               mismatch_cnt,
	output int               outstanding
);
	import cmfs_pkg::*;

	typedef struct packed {
		face_t         face;
		logic [FB-1:0] tex_u;
		logic [FB-1:0] tex_v;
		logic          degenerate;
	} face_uv_t;

	localparam longint UV_MAX = (64'sd1 <<< FB) - 1;

	face_uv_t pending_uv_q[$];

	// round half up: (n + m) * 2^F / 2m, one saturates to all ones
	function automatic longint uv_coord(input longint n, input longint m);
		longint num;
		longint t;
		num = ((n + m) <<< FB) + m;
		t = num / (2 * m);
		if (t > UV_MAX)
			t = UV_MAX;
		return t;
	endfunction

	function automatic face_uv_t predict_face_uv(input logic [IN_W-1:0] beat);
		longint x, y, z;
		longint ax, ay, az;
		longint m, nu, nv;
		face_uv_t r;
		x = longint'($signed(beat[CW-1:0]));
		y = longint'($signed(beat[2*CW-1:CW]));
		z = longint'($signed(beat[3*CW-1:2*CW]));
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = (z < 0) ? -z : z;
		r = '0;
		if (ax == 0 && ay == 0 && az == 0) begin
			r.face = FACE_NEG_Z;
			r.tex_u = {1'b1, {(FB-1){1'b0}}};
			r.tex_v = {1'b1, {(FB-1){1'b0}}};
			r.degenerate = 1'b1;
			return r;
		end
		// x needs a strict win, y beats z only strictly
		if (ax > ay && ax > az) begin
			m = ax;
			if (x > 0) begin
				r.face = FACE_POS_X;
				nu = -z;
			end else begin
				r.face = FACE_NEG_X;
				nu = z;
			end
			nv = -y;
		end else if (ay > az) begin
			m = ay;
			nu = x;
			if (y > 0) begin
				r.face = FACE_POS_Y;
				nv = z;
			end else begin
				r.face = FACE_NEG_Y;
				nv = -z;
			end
		end else begin
			m = az;
			if (z > 0) begin
				r.face = FACE_POS_Z;
				nu = x;
			end else begin
				r.face = FACE_NEG_Z;
				nu = -x;
			end
			nv = -y;
		end
		r.tex_u = FB'(uv_coord(nu, m));
		r.tex_v = FB'(uv_coord(nv, m));
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		face_uv_t want;
		face_uv_t got;
		if (!arst_n) begin
			pending_uv_q.delete();
		end else begin
			// retire the output beat before queuing this edge's input beat
			if (m_tvalid && m_tready) begin
				got.face = m_tdata[FACE_W-1:0];
				got.tex_u = m_tdata[FACE_W +: FB];
				got.tex_v = m_tdata[FACE_W+FB +: FB];
				got.degenerate = m_tuser;
				if (pending_uv_q.size() == 0) begin
					if (mismatch_cnt < 10)
						$display("%0t: unexpected beat face %0d u %0d v %0d degen %0b",
							$realtime, got.face, got.tex_u, got.tex_v, got.degenerate);
					mismatch_cnt++;
				end else begin
					want = pending_uv_q.pop_front();
					if (got.face != want.face || got.tex_u != want.tex_u ||
					    got.tex_v != want.tex_v || got.degenerate != want.degenerate) begin
						if (mismatch_cnt < 10)
							$display({"%0t: mismatch face %0d/%0d u %0d/%0d v %0d/%0d",
								" degen %0b/%0b (exp/act)"}, $realtime,
								want.face, got.face, want.tex_u, got.tex_u,
								want.tex_v, got.tex_v, want.degenerate, got.degenerate);
						mismatch_cnt++;
					end
				end
			end
			if (s_tvalid && s_tready)
				pending_uv_q.push_back(predict_face_uv(s_tdata));
		end
		outstanding = pending_uv_q.size();
	end

endmodule

// ===== dv/cubemap_face_select_uv_tb.sv =====
`timescale 1ns / 1ps

module cubemap_face_select_uv_tb;
	import cmfs_pkg::*;

	localparam int CW = CMFS_COMPONENT_WIDTH;
	localparam int FB = CMFS_UV_FRACTION_BITS;
	localparam int IN_W = ((3*CW+7)/8)*8;
	localparam int OUT_W = ((FACE_W+2*FB+7)/8)*8;
	localparam int RANDOM_BEATS = 850;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 1000000;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tuser;

	int mismatch_cnt;
	int outstanding;
	int hold_req;
	int hold_seen;
	int ready_run;
	bit ready_flip;
	int unsigned cycle_cnt;
	bit no_idle;
	logic [IN_W-1:0] directed_q[$];

	cubemap_face_select_uv dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser)
	);

	cubemap_face_select_uv_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.mismatch_cnt (mismatch_cnt),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [IN_W-1:0] pack_dir(input int x, input int y, input int z);
		logic [IN_W-1:0] w;
		w = '0;
		w[CW-1:0] = CW'(x);
		w[CW +: CW] = CW'(y);
		w[2*CW +: CW] = CW'(z);
		return w;
	endfunction

	function automatic logic [IN_W-1:0] rand_dir();
		int kind;
		int sel;
		logic [CW-1:0] mag, a, b, d;
		kind = $urandom_range(0, 99);
		sel = $urandom_range(0, 2);
		a = CW'($urandom);
		b = CW'($urandom);
		d = CW'($urandom);
		if (kind < 20) begin
			// small values, zeros common
			a = CW'($urandom_range(0, 16)) - CW'(8);
			b = CW'($urandom_range(0, 16)) - CW'(8);
			d = CW'($urandom_range(0, 16)) - CW'(8);
		end else if (kind < 40) begin
			// two magnitudes equal, sometimes all three
			mag = CW'($urandom);
			if ($urandom_range(0, 3) == 0)
				mag = {1'b1, {(CW-1){1'b0}}};
			a = $urandom_range(0, 1) ? mag : -mag;
			b = $urandom_range(0, 1) ? mag : -mag;
			if ($urandom_range(0, 3) == 0)
				d = $urandom_range(0, 1) ? mag : -mag;
		end else if (kind < 52) begin
			a = $urandom_range(0, 1) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else if (kind < 58) begin
			a = (kind < 54) ? '0 : a;
			b = '0;
			d = '0;
		end
		case (sel)
			0: return pack_dir(int'(a), int'(b), int'(d));
			1: return pack_dir(int'(b), int'(d), int'(a));
			default: return pack_dir(int'(d), int'(a), int'(b));
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 70);
	endfunction

	task automatic send_dir(input logic [IN_W-1:0] beat, input int gap);
		s_tdata <= beat;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// one edge first so the checker has queued the last accepted beat
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	// receiver: runs of steady, random and stalled ready, plus one long hold-off
	initial begin
		m_tready = 1'b0;
		hold_seen = 0;
		ready_run = 0;
		ready_flip = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			int r;
			@(posedge clk);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				ready_run = 0;
			end else if (ready_run > 0) begin
				ready_run--;
				if (ready_flip)
					m_tready <= 1'($urandom_range(0, 1));
			end else begin
				r = $urandom_range(0, 99);
				ready_flip = 1'b0;
				if (r < 30) begin
					m_tready <= 1'b1;
					ready_run = $urandom_range(20, 80);
				end else if (r < 80) begin
					m_tready <= 1'($urandom_range(0, 1));
					ready_flip = 1'b1;
					ready_run = $urandom_range(4, 16);
				end else if (r < 95) begin
					m_tready <= 1'b0;
					ready_run = $urandom_range(2, 8);
				end else begin
					m_tready <= 1'b0;
					ready_run = $urandom_range(25, 60);
				end
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		hold_req = 0;
		no_idle = 1'b0;

		directed_q.push_back(pack_dir(0, 0, 0));
		directed_q.push_back(pack_dir(32767, 0, 0));
		directed_q.push_back(pack_dir(-32768, 0, 0));
		directed_q.push_back(pack_dir(0, 32767, 0));
		directed_q.push_back(pack_dir(0, -32768, 0));
		directed_q.push_back(pack_dir(0, 0, 32767));
		directed_q.push_back(pack_dir(0, 0, -32768));
		directed_q.push_back(pack_dir(-32768, -32768, -32768));
		directed_q.push_back(pack_dir(32767, 32767, 0));
		directed_q.push_back(pack_dir(0, -5, 5));
		directed_q.push_back(pack_dir(7, -7, 3));
		directed_q.push_back(pack_dir(-32768, 32767, 32767));
		directed_q.push_back(pack_dir(32767, -32768, -32768));
		directed_q.push_back(pack_dir(-32768, 0, -32768));
		directed_q.push_back(pack_dir(32767, -32767, 32766));
		directed_q.push_back(pack_dir(1, 0, 0));
		directed_q.push_back(pack_dir(-1, 0, 0));
		directed_q.push_back(pack_dir(0, 1, 0));
		directed_q.push_back(pack_dir(0, 0, 1));
		directed_q.push_back(pack_dir(-1, -1, -1));
		directed_q.push_back(pack_dir(3, 1, -1));
		directed_q.push_back(pack_dir(2, 1, -1));
		directed_q.push_back(pack_dir(-3, 3, -3));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_q[i])
			send_dir(directed_q[i], pick_gap());
		drain_results();

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i % 40 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			// long output stall while beats keep coming, fills the pipe
			if (i == 200)
				hold_req++;
			if (i == 500)
				drain_results();
			send_dir(rand_dir(), no_idle ? 0 : pick_gap());
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
